/* src/bsfd_pkg.sv */
// Shared types, codes and per-byte decode functions of the byte-stuffed deframer.
// Used by bsfd_parser, bsfd_queue and byte_stuffed_frame_deframer; no dependencies.
package bsfd_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_HEAD   = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_CMD    = 3'd2;
    localparam logic [2:0] PH_ADDR   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_TERM   = 3'd5;

    // Request operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    // Link byte values
    localparam logic [7:0] BYTE_ESC    = 8'hFE;
    localparam logic [7:0] BYTE_ESC_FF = 8'hFD;
    localparam logic [7:0] BYTE_ESC_FE = 8'hFC;
    localparam logic [7:0] BYTE_TERM   = 8'hFF;

    localparam logic [7:0]  HDR_BYTES       = 8'd4;   // two command + two address bytes
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd50;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]  phase;
        logic        escape_pending;
        logic [7:0]  frame_length;
        logic [7:0]  field_counter;
        logic [15:0] address_accum;
        logic [15:0] idle_ticks;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [15:0] source_address;
        logic [7:0]  payload_length;
        logic        last;
    } result_t;

    typedef struct packed {
        parse_state_t st;
        logic         emit;
        result_t      res;
    } feed_out_t;

    // Up to two results written into the queue in one cycle
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic parse_state_t go_head(input parse_state_t st);
        parse_state_t s;
        s = st;
        s.phase          = PH_HEAD;
        s.escape_pending = 1'b0;
        s.field_counter  = 8'd0;
        return s;
    endfunction

    // One decoded byte in the current phase
    function automatic feed_out_t feed(input parse_state_t st, input logic [7:0] b);
        feed_out_t  fo;
        logic [7:0] cnt_inc;
        logic [8:0] cnt_sum;
        fo.st   = st;
        fo.emit = 1'b0;
        fo.res  = '0;
        cnt_inc = st.field_counter + 8'd1;
        cnt_sum = {1'b0, cnt_inc} + {1'b0, HDR_BYTES};
        unique case (st.phase)
            PH_LENGTH:
            begin
                fo.st.frame_length = b;
                if (b < HDR_BYTES)
                begin
                    fo.st         = go_head(fo.st);
                    fo.emit       = 1'b1;
                    fo.res.kind   = KIND_DROP;
                end
                else
                begin
                    fo.st.field_counter = 8'd0;
                    fo.st.phase         = PH_CMD;
                end
            end
            PH_CMD:
            begin
                if (st.field_counter != 8'd0)
                begin
                    fo.st.field_counter = 8'd0;
                    fo.st.address_accum = 16'd0;
                    fo.st.phase         = PH_ADDR;
                end
                else
                begin
                    fo.st.field_counter = cnt_inc;
                end
            end
            PH_ADDR:
            begin
                if (st.field_counter == 8'd0)
                begin
                    fo.st.address_accum = {b, 8'd0};
                    fo.st.field_counter = 8'd1;
                end
                else
                begin
                    fo.st.address_accum = {st.address_accum[15:8], b};
                    fo.st.field_counter = 8'd0;
                    fo.st.phase = (st.frame_length == HDR_BYTES) ? PH_TERM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                fo.emit             = 1'b1;
                fo.res.kind         = KIND_PAYLOAD;
                fo.res.payload_byte = b;
                fo.res.byte_index   = st.field_counter;
                fo.st.field_counter = cnt_inc;
                if (cnt_sum >= {1'b0, st.frame_length})
                begin
                    fo.st.field_counter = 8'd0;
                    fo.st.phase         = PH_TERM;
                end
            end
            PH_TERM:
            begin
                if (b == BYTE_TERM)
                begin
                    fo.st                 = go_head(st);
                    fo.emit               = 1'b1;
                    fo.res.kind           = KIND_DONE;
                    fo.res.source_address = st.address_accum;
                    fo.res.payload_length = st.frame_length - HDR_BYTES;
                end
            end
            default:
            begin
                // header search; unused codes behave the same
                fo.st.phase = PH_HEAD;
                if (b == BYTE_ESC)
                begin
                    fo.st.phase         = PH_LENGTH;
                    fo.st.field_counter = 8'd0;
                end
            end
        endcase
        return fo;
    endfunction

    // Raw link byte with no escape pending
    function automatic feed_out_t handle_raw(input parse_state_t st, input logic [7:0] b);
        feed_out_t fo;
        logic      stuffing;
        stuffing = (st.phase == PH_LENGTH) || (st.phase == PH_CMD) ||
                   (st.phase == PH_ADDR) || (st.phase == PH_DATA);
        if (stuffing && (b == BYTE_ESC))
        begin
            fo                   = '0;
            fo.st                = st;
            fo.st.escape_pending = 1'b1;
        end
        else
        begin
            fo = feed(st, b);
        end
        return fo;
    endfunction

endpackage

/* src/bsfd_parser.sv */
// Front part of the deframer: takes requests, unstuffs and parses, holds the gap timeout.
// Depends on bsfd_pkg; pushes up to two results per request into bsfd_queue.
module bsfd_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic [15:0]     cfg_write_data,
    input  logic            item_valid,
    output logic            item_stall,
    input  logic            operation,
    input  logic [7:0]      rx_byte,
    input  logic            room,
    output bsfd_pkg::push_t push
);

    bsfd_pkg::parse_state_t state_reg, state_next;
    logic [15:0]            gap_timeout_reg;
    bsfd_pkg::feed_out_t    fa, fb;
    bsfd_pkg::parse_state_t s_in;
    logic                   accept;
    logic                   partial;

    assign accept     = item_valid && room;
    assign item_stall = !room;
    assign partial    = (state_reg.phase != bsfd_pkg::PH_HEAD) || state_reg.escape_pending;

    always_comb
    begin
        s_in = state_reg;
        fa   = '0;
        fb   = '0;
        fa.st = state_reg;
        fb.st = state_reg;
        if (operation == bsfd_pkg::OP_TICK)
        begin
            if (partial)
            begin
                if (state_reg.idle_ticks >= gap_timeout_reg)
                begin
                    fa.st            = bsfd_pkg::go_head(state_reg);
                    fa.st.idle_ticks = 16'd0;
                    fa.emit          = 1'b1;
                    fa.res.kind      = bsfd_pkg::KIND_DROP;
                end
                else
                begin
                    fa.st.idle_ticks = state_reg.idle_ticks + 16'd1;
                end
            end
            else
            begin
                fa.st.idle_ticks = 16'd0;
            end
            fb.st = fa.st;
        end
        else
        begin
            s_in.idle_ticks = 16'd0;
            if (state_reg.escape_pending)
            begin
                s_in.escape_pending = 1'b0;
                if (rx_byte == bsfd_pkg::BYTE_ESC_FF)
                begin
                    fa    = bsfd_pkg::feed(s_in, bsfd_pkg::BYTE_TERM);
                    fb.st = fa.st;
                end
                else if (rx_byte == bsfd_pkg::BYTE_ESC_FE)
                begin
                    fa    = bsfd_pkg::feed(s_in, bsfd_pkg::BYTE_ESC);
                    fb.st = fa.st;
                end
                else
                begin
                    // literal 0xFE, then the byte itself in the new phase
                    fa = bsfd_pkg::feed(s_in, bsfd_pkg::BYTE_ESC);
                    fb = bsfd_pkg::handle_raw(fa.st, rx_byte);
                end
            end
            else
            begin
                fa    = bsfd_pkg::handle_raw(s_in, rx_byte);
                fb.st = fa.st;
            end
        end
        state_next = fb.st;
    end

    always_comb
    begin
        push         = '0;
        push.v0      = accept && (fa.emit || fb.emit);
        push.v1      = accept && fa.emit && fb.emit;
        push.r0      = fa.emit ? fa.res : fb.res;
        push.r0.last = !(fa.emit && fb.emit);
        push.r1      = fb.res;
        push.r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '{phase:          bsfd_pkg::PH_HEAD,
                                 escape_pending: 1'b0,
                                 frame_length:   8'd0,
                                 field_counter:  8'd0,
                                 address_accum:  16'd0,
                                 idle_ticks:     16'd0};
            gap_timeout_reg <= bsfd_pkg::GAP_TIMEOUT_RST;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_write_en)
            begin
                gap_timeout_reg <= cfg_write_data;
            end
        end
    end

endmodule

/* src/bsfd_queue.sv */
// Back part of the deframer: result queue taking two writes a cycle, one result out.
// Depends on bsfd_pkg; fed by bsfd_parser.
module bsfd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  bsfd_pkg::push_t   push,
    output logic              room,
    output logic              result_valid,
    input  logic              result_stall,
    output bsfd_pkg::result_t result
);

    bsfd_pkg::result_t             mem_reg [bsfd_pkg::QDEPTH];
    logic [bsfd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bsfd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bsfd_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic [bsfd_pkg::QPTR_W-1:0]   wr_ptr_p1;
    logic [bsfd_pkg::QCNT_W-1:0]   n_push;
    logic                          pop;

    assign result_valid = (count_reg != '0);
    assign result       = mem_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // room for the worst case of two results from one request
    assign room         = (count_reg <= bsfd_pkg::QCNT_W'(bsfd_pkg::QDEPTH - 2));

    assign wr_ptr_p1    = wr_ptr_reg + 1'b1;
    assign n_push       = bsfd_pkg::QCNT_W'(push.v0) + bsfd_pkg::QCNT_W'(push.v1);
    assign wr_ptr_next  = wr_ptr_reg + n_push[bsfd_pkg::QPTR_W-1:0];
    assign rd_ptr_next  = rd_ptr_reg + bsfd_pkg::QPTR_W'(pop);
    assign count_next   = count_reg + n_push - bsfd_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bsfd_pkg::QCNT_W'(bsfd_pkg::QDEPTH))
        else $error("result queue overfilled");

    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result pushed without first");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> room)
        else $error("result pushed without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + $past(n_push)
                              - bsfd_pkg::QCNT_W'($past(pop)))
        else $error("queue count out of step");

endmodule

/* src/byte_stuffed_frame_deframer.sv */
// Top level of the byte-stuffed frame deframer: parser front end and result queue.
// Depends on bsfd_pkg, bsfd_parser and bsfd_queue.
//
//  channel   handshake                    payload
//  -------   --------------------------   -----------------------------------------------
//  request   item_valid / item_stall      operation, rx_byte
//  result    result_valid / result_stall  kind, payload_byte, byte_index, source_address,
//                                         payload_length, last
//  config    cfg_write_en                 cfg_write_data (gap timeout ticks)
//
// One request is taken per cycle while the queue has room; the parser decodes it in the
// cycle it is taken and writes its zero, one or two results into a four-entry queue that
// is read out in order. The queue must have room for two results to take a request, so a
// stalled output backs up into item_stall once three or four results are pending.
// Reset (rst_n low, asynchronous) returns the parser to header search, empties the
// queue and sets the gap timeout to 50 ticks.
module byte_stuffed_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    // requests
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic [7:0]  rx_byte,
    // results
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  byte_index,
    output logic [15:0] source_address,
    output logic [7:0]  payload_length,
    output logic        last
);

    bsfd_pkg::push_t   push;
    bsfd_pkg::result_t result;
    logic              room;

    // Front end: unstuffing, frame parsing and the quiet-gap timer
    bsfd_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operation      (operation),
        .rx_byte        (rx_byte),
        .room           (room),
        .push           (push)
    );

    // Back end: queued results drained one per cycle toward the consumer while result_stall is low
    bsfd_queue u_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign kind           = result.kind;
    assign payload_byte   = result.payload_byte;
    assign byte_index     = result.byte_index;
    assign source_address = result.source_address;
    assign payload_length = result.payload_length;
    assign last           = result.last;

endmodule
